FILE: rtl/core/cst_pkg.sv
// ----------------------------------------------------------------
// cst_pkg
// Types, character codes, token classes and byte classification
// shared by the source tokenizer modules.
// ----------------------------------------------------------------
package cst_pkg;

    localparam int OUT_W = 24;

    typedef logic [5:0] tclass_t;

    localparam tclass_t CL_IDENT      = 6'd0;
    localparam tclass_t CL_INT        = 6'd1;
    localparam tclass_t CL_FLOAT      = 6'd2;
    localparam tclass_t CL_STRING     = 6'd3;
    localparam tclass_t CL_CHAR       = 6'd4;
    localparam tclass_t OP_LBRACE     = 6'd5;
    localparam tclass_t OP_RBRACE     = 6'd6;
    localparam tclass_t OP_LPAREN     = 6'd7;
    localparam tclass_t OP_RPAREN     = 6'd8;
    localparam tclass_t OP_LBRACK     = 6'd9;
    localparam tclass_t OP_RBRACK     = 6'd10;
    localparam tclass_t OP_COMMA      = 6'd11;
    localparam tclass_t OP_SEMI       = 6'd12;
    localparam tclass_t OP_DOT        = 6'd13;
    localparam tclass_t OP_QUEST      = 6'd14;
    localparam tclass_t OP_COLON      = 6'd15;
    localparam tclass_t OP_DEFINE     = 6'd16;
    localparam tclass_t OP_ASSIGN     = 6'd17;
    localparam tclass_t OP_EQ         = 6'd18;
    localparam tclass_t OP_ADD        = 6'd19;
    localparam tclass_t OP_ADD_ASSIGN = 6'd20;
    localparam tclass_t OP_SUB        = 6'd21;
    localparam tclass_t OP_SUB_ASSIGN = 6'd22;
    localparam tclass_t OP_ARROW      = 6'd23;
    localparam tclass_t OP_MUL        = 6'd24;
    localparam tclass_t OP_MUL_ASSIGN = 6'd25;
    localparam tclass_t OP_DIV        = 6'd26;
    localparam tclass_t OP_DIV_ASSIGN = 6'd27;
    localparam tclass_t OP_MOD        = 6'd28;
    localparam tclass_t OP_MOD_ASSIGN = 6'd29;
    localparam tclass_t OP_AND        = 6'd30;
    localparam tclass_t OP_LAND       = 6'd31;
    localparam tclass_t OP_OR         = 6'd32;
    localparam tclass_t OP_LOR        = 6'd33;
    localparam tclass_t OP_BITNOT     = 6'd34;
    localparam tclass_t OP_NOT        = 6'd35;
    localparam tclass_t OP_NE         = 6'd36;
    localparam tclass_t OP_LT         = 6'd37;
    localparam tclass_t OP_LE         = 6'd38;
    localparam tclass_t OP_GT         = 6'd39;
    localparam tclass_t OP_GE         = 6'd40;
    localparam tclass_t CL_UNKNOWN    = 6'd41;
    localparam tclass_t CL_END        = 6'd42;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_XU    = "X";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_E     = "e";
    localparam logic [7:0] CH_EU    = "E";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_AMP   = "&";
    localparam logic [7:0] CH_BAR   = "|";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_UND   = "_";

    typedef struct packed {
        logic alpha;
        logic digit;
        logic hexd;
        logic eol;
        logic blank;
    } ccls_t;

    typedef struct packed {
        logic [7:0] ch;
        ccls_t      cc;
    } qent_t;

    typedef struct packed {
        tclass_t          cls;
        logic [OUT_W-1:0] off;
        logic [OUT_W-1:0] len;
        logic [OUT_W-1:0] line;
        logic [OUT_W-1:0] col;
        logic             last;
    } token_t;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_HEX, M_DEC, M_FRAC, M_EXPCHK, M_EXPD,
        M_STR, M_STR_ESC, M_CHR, M_CHR_ESC, M_CHR_END, M_LINE, M_BLOCK
    } mode_t;

    typedef enum logic [1:0] {
        ST_NEED, ST_GO, ST_END
    } step_t;

    typedef struct packed {
        tclass_t cls;
        logic    two;
    } punct_t;

    function automatic ccls_t classify(input logic [7:0] c);
        ccls_t r;
        r.alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UND;
        r.digit = (c >= "0" && c <= "9");
        r.hexd  = r.digit || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        r.eol   = (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
        r.blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        return r;
    endfunction

    function automatic logic wants_pair(input logic [7:0] c);
        logic r;
        case (c)
            ":", "=", "+", "-", "*", "/", "%", "&", "|", "!", "<", ">": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic punct_t punct(input logic [7:0] c0, input logic [7:0] c1);
        punct_t p;
        p.two = 1'b0;
        p.cls = CL_UNKNOWN;
        case (c0)
            "{": p.cls = OP_LBRACE;
            "}": p.cls = OP_RBRACE;
            "(": p.cls = OP_LPAREN;
            ")": p.cls = OP_RPAREN;
            "[": p.cls = OP_LBRACK;
            "]": p.cls = OP_RBRACK;
            ",": p.cls = OP_COMMA;
            ";": p.cls = OP_SEMI;
            ".": p.cls = OP_DOT;
            "?": p.cls = OP_QUEST;
            "~": p.cls = OP_BITNOT;
            ":":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_DEFINE : OP_COLON;
            end
            "=":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_EQ : OP_ASSIGN;
            end
            "+":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_ADD_ASSIGN : OP_ADD;
            end
            "-":
            begin
                p.two = (c1 == CH_EQ) || (c1 == CH_GT);
                p.cls = (c1 == CH_EQ) ? OP_SUB_ASSIGN : ((c1 == CH_GT) ? OP_ARROW : OP_SUB);
            end
            "*":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_MUL_ASSIGN : OP_MUL;
            end
            "/":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_DIV_ASSIGN : OP_DIV;
            end
            "%":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_MOD_ASSIGN : OP_MOD;
            end
            "&":
            begin
                p.two = (c1 == CH_AMP);
                p.cls = p.two ? OP_LAND : OP_AND;
            end
            "|":
            begin
                p.two = (c1 == CH_BAR);
                p.cls = p.two ? OP_LOR : OP_OR;
            end
            "!":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_NE : OP_NOT;
            end
            "<":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_LE : OP_LT;
            end
            ">":
            begin
                p.two = (c1 == CH_EQ);
                p.cls = p.two ? OP_GE : OP_GT;
            end
            default: p.cls = CL_UNKNOWN;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/cst_front.sv
// ----------------------------------------------------------------
// cst_front
// Accepts source bytes, tags each with its character class and
// queues it for the scanner.
// ----------------------------------------------------------------
module cst_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     text_byte,
    input  logic           deq,
    output logic           q_valid,
    output cst_pkg::qent_t q_data
);

    cst_pkg::qent_t mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign in_stall = (cnt_reg == 3'd4);
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_data   = mem[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = deq && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{ch: text_byte, cc: cst_pkg::classify(text_byte)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/cst_outq.sv
// ----------------------------------------------------------------
// cst_outq
// Four-entry token queue in front of the output port; absorbs the
// short bursts of tokens that one byte can release.
// ----------------------------------------------------------------
module cst_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cst_pkg::token_t push_data,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output cst_pkg::token_t head
);

    cst_pkg::token_t mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       wr;
    logic       pop;

    assign full      = (cnt_reg == 3'd4);
    assign out_valid = (cnt_reg != 3'd0);
    assign head      = mem[rd_ptr_reg];
    assign wr        = push && !full;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {2'b00, wr} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/cst_scan.sv
// ----------------------------------------------------------------
// cst_scan
// Scanner back end: a three-byte lookahead window and one scan step
// per cycle while the output queue is not full. Tokens pass through a
// one-deep hold so the final token of each byte can be marked.
// ----------------------------------------------------------------
module cst_scan #(
    parameter int POSITION_BITS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  cst_pkg::qent_t  q_data,
    output logic            deq,
    input  logic            oq_full,
    output logic            push,
    output cst_pkg::token_t push_data
);

    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] MAXV = {PB{1'b1}};
    localparam logic [PB-1:0] ONE  = {{(PB-1){1'b0}}, 1'b1};

    typedef struct packed {
        cst_pkg::step_t   st;
        logic [1:0]       adv;
        logic             skip_lf;
        logic             mark;
        logic             emit;
        cst_pkg::tclass_t cls;
        cst_pkg::mode_t   mode;
        logic             sfp_set;
    } dec_t;

    function automatic logic [PB-1:0] sat1(input logic [PB-1:0] v);
        return (v == MAXV) ? MAXV : v + ONE;
    endfunction

    function automatic logic [PB-1:0] sat2(input logic [PB-1:0] v);
        return (v >= MAXV - ONE) ? MAXV : v + {ONE[PB-2:0], 1'b0};
    endfunction

    cst_pkg::mode_t  mode_reg, mode_next;
    cst_pkg::qent_t  win_reg [3];
    cst_pkg::qent_t  win_next [3];
    logic [1:0]      cnt_reg, cnt_next;
    logic [PB-1:0]   off_reg, off_next;
    logic [PB-1:0]   line_reg, line_next;
    logic [PB-1:0]   col_reg, col_next;
    logic            acr_reg, acr_next;
    logic [PB-1:0]   ts_off_reg, ts_off_next;
    logic [PB-1:0]   ts_line_reg, ts_line_next;
    logic [PB-1:0]   ts_col_reg, ts_col_next;
    logic            sfp_reg, sfp_next;
    cst_pkg::token_t pend_reg, pend_next;
    logic            pend_vld_reg, pend_vld_next;

    cst_pkg::qent_t  c0, c1, c2, nul_ent;
    logic            zero_last, av1, av2, en;
    dec_t            d;
    cst_pkg::punct_t p;
    logic [PB-1:0]   off_a, st_off, st_line, st_col;
    logic [1:0]      take;

    assign en      = !oq_full;
    assign nul_ent = '{ch: cst_pkg::CH_NUL, cc: cst_pkg::classify(cst_pkg::CH_NUL)};

    // an end byte can only sit at the tail of the window
    always_comb
    begin
        case (cnt_reg)
            2'd1:    zero_last = (win_reg[0].ch == cst_pkg::CH_NUL);
            2'd2:    zero_last = (win_reg[1].ch == cst_pkg::CH_NUL);
            2'd3:    zero_last = (win_reg[2].ch == cst_pkg::CH_NUL);
            default: zero_last = 1'b0;
        endcase
        av1 = (cnt_reg > 2'd1) || zero_last;
        av2 = (cnt_reg > 2'd2) || zero_last;
        c0  = win_reg[0];
        c1  = (cnt_reg > 2'd1) ? win_reg[1] : nul_ent;
        c2  = (cnt_reg > 2'd2) ? win_reg[2] : nul_ent;
        p   = cst_pkg::punct(c0.ch, c1.ch);
    end

    // one scan step
    always_comb
    begin
        d      = '0;
        d.st   = cst_pkg::ST_GO;
        d.mode = mode_reg;
        d.cls  = cst_pkg::CL_UNKNOWN;
        if (cnt_reg == 2'd0)
        begin
            d.st = cst_pkg::ST_NEED;
        end
        else if (acr_reg && c0.ch == cst_pkg::CH_LF)
        begin
            d.skip_lf = 1'b1;
        end
        else
        begin
            case (mode_reg)
                cst_pkg::M_IDLE:
                begin
                    if (c0.ch == cst_pkg::CH_NUL)
                    begin
                        d.st = cst_pkg::ST_END;
                    end
                    else if (c0.cc.blank)
                    begin
                        d.adv = 2'd1;
                    end
                    else
                    begin
                        d.mark = 1'b1;
                        if (c0.ch == cst_pkg::CH_SLASH && !av1)
                        begin
                            d.st = cst_pkg::ST_NEED;
                        end
                        else if (c0.ch == cst_pkg::CH_SLASH && c1.ch == cst_pkg::CH_SLASH)
                        begin
                            d.mode = cst_pkg::M_LINE;
                        end
                        else if (c0.ch == cst_pkg::CH_SLASH && c1.ch == cst_pkg::CH_STAR)
                        begin
                            d.adv  = 2'd2;
                            d.mode = cst_pkg::M_BLOCK;
                        end
                        else if (c0.cc.alpha)
                        begin
                            d.adv  = 2'd1;
                            d.mode = cst_pkg::M_IDENT;
                        end
                        else if (c0.cc.digit)
                        begin
                            if (c0.ch == cst_pkg::CH_ZERO && !av1)
                            begin
                                d.st = cst_pkg::ST_NEED;
                            end
                            else if (c0.ch == cst_pkg::CH_ZERO
                                     && (c1.ch == cst_pkg::CH_X || c1.ch == cst_pkg::CH_XU))
                            begin
                                d.adv  = 2'd2;
                                d.mode = cst_pkg::M_HEX;
                            end
                            else
                            begin
                                d.adv  = 2'd1;
                                d.mode = cst_pkg::M_DEC;
                            end
                        end
                        else if (c0.ch == cst_pkg::CH_DQ)
                        begin
                            d.adv  = 2'd1;
                            d.mode = cst_pkg::M_STR;
                        end
                        else if (c0.ch == cst_pkg::CH_SQ)
                        begin
                            d.adv  = 2'd1;
                            d.mode = cst_pkg::M_CHR;
                        end
                        else if (cst_pkg::wants_pair(c0.ch) && !av1)
                        begin
                            d.st = cst_pkg::ST_NEED;
                        end
                        else
                        begin
                            d.adv  = p.two ? 2'd2 : 2'd1;
                            d.emit = 1'b1;
                            d.cls  = p.cls;
                        end
                    end
                end
                cst_pkg::M_IDENT:
                begin
                    if (c0.cc.alpha || c0.cc.digit)
                    begin
                        d.adv = 2'd1;
                    end
                    else
                    begin
                        d.emit = 1'b1;
                        d.cls  = cst_pkg::CL_IDENT;
                    end
                end
                cst_pkg::M_HEX:
                begin
                    if (c0.cc.hexd)
                    begin
                        d.adv = 2'd1;
                    end
                    else
                    begin
                        d.emit = 1'b1;
                        d.cls  = cst_pkg::CL_INT;
                    end
                end
                cst_pkg::M_DEC, cst_pkg::M_FRAC:
                begin
                    if (c0.cc.digit)
                    begin
                        d.adv = 2'd1;
                    end
                    else if (mode_reg == cst_pkg::M_DEC && c0.ch == cst_pkg::CH_DOT && !av1)
                    begin
                        d.st = cst_pkg::ST_NEED;
                    end
                    else if (mode_reg == cst_pkg::M_DEC && c0.ch == cst_pkg::CH_DOT
                             && c1.cc.digit)
                    begin
                        d.sfp_set = 1'b1;
                        d.adv     = 2'd1;
                        d.mode    = cst_pkg::M_FRAC;
                    end
                    else
                    begin
                        d.mode = cst_pkg::M_EXPCHK;
                    end
                end
                cst_pkg::M_EXPCHK:
                begin
                    if ((c0.ch == cst_pkg::CH_E || c0.ch == cst_pkg::CH_EU) && !av1)
                    begin
                        d.st = cst_pkg::ST_NEED;
                    end
                    else if ((c0.ch == cst_pkg::CH_E || c0.ch == cst_pkg::CH_EU)
                             && c1.cc.digit)
                    begin
                        d.sfp_set = 1'b1;
                        d.adv     = 2'd1;
                        d.mode    = cst_pkg::M_EXPD;
                    end
                    else if ((c0.ch == cst_pkg::CH_E || c0.ch == cst_pkg::CH_EU)
                             && (c1.ch == cst_pkg::CH_PLUS || c1.ch == cst_pkg::CH_MINUS)
                             && !av2)
                    begin
                        d.st = cst_pkg::ST_NEED;
                    end
                    else if ((c0.ch == cst_pkg::CH_E || c0.ch == cst_pkg::CH_EU)
                             && (c1.ch == cst_pkg::CH_PLUS || c1.ch == cst_pkg::CH_MINUS)
                             && c2.cc.digit)
                    begin
                        d.sfp_set = 1'b1;
                        d.adv     = 2'd2;
                        d.mode    = cst_pkg::M_EXPD;
                    end
                    else
                    begin
                        d.emit = 1'b1;
                        d.cls  = sfp_reg ? cst_pkg::CL_FLOAT : cst_pkg::CL_INT;
                    end
                end
                cst_pkg::M_EXPD:
                begin
                    if (c0.cc.digit)
                    begin
                        d.adv = 2'd1;
                    end
                    else
                    begin
                        d.emit = 1'b1;
                        d.cls  = cst_pkg::CL_FLOAT;
                    end
                end
                cst_pkg::M_STR:
                begin
                    if (c0.ch == cst_pkg::CH_DQ)
                    begin
                        d.adv  = 2'd1;
                        d.emit = 1'b1;
                        d.cls  = cst_pkg::CL_STRING;
                    end
                    else if (c0.cc.eol)
                    begin
                        d.emit = 1'b1;
                        d.cls  = cst_pkg::CL_STRING;
                    end
                    else if (c0.ch == cst_pkg::CH_BSL)
                    begin
                        d.adv  = 2'd1;
                        d.mode = cst_pkg::M_STR_ESC;
                    end
                    else
                    begin
                        d.adv = 2'd1;
                    end
                end
                cst_pkg::M_STR_ESC:
                begin
                    d.adv  = (c0.ch != cst_pkg::CH_NUL) ? 2'd1 : 2'd0;
                    d.mode = cst_pkg::M_STR;
                end
                cst_pkg::M_CHR:
                begin
                    if (c0.ch == cst_pkg::CH_BSL)
                    begin
                        d.adv  = 2'd1;
                        d.mode = cst_pkg::M_CHR_ESC;
                    end
                    else
                    begin
                        d.adv  = c0.cc.eol ? 2'd0 : 2'd1;
                        d.mode = cst_pkg::M_CHR_END;
                    end
                end
                cst_pkg::M_CHR_ESC:
                begin
                    d.adv  = (c0.ch != cst_pkg::CH_NUL) ? 2'd1 : 2'd0;
                    d.mode = cst_pkg::M_CHR_END;
                end
                cst_pkg::M_CHR_END:
                begin
                    d.adv  = (c0.ch == cst_pkg::CH_SQ) ? 2'd1 : 2'd0;
                    d.emit = 1'b1;
                    d.cls  = cst_pkg::CL_CHAR;
                end
                cst_pkg::M_LINE:
                begin
                    if (c0.cc.eol)
                    begin
                        d.mode = cst_pkg::M_IDLE;
                    end
                    else
                    begin
                        d.adv = 2'd1;
                    end
                end
                cst_pkg::M_BLOCK:
                begin
                    if (c0.ch == cst_pkg::CH_NUL)
                    begin
                        d.mode = cst_pkg::M_IDLE;
                    end
                    else if (c0.ch == cst_pkg::CH_STAR && !av1)
                    begin
                        d.st = cst_pkg::ST_NEED;
                    end
                    else if (c0.ch == cst_pkg::CH_STAR && c1.ch == cst_pkg::CH_SLASH)
                    begin
                        d.adv  = 2'd2;
                        d.mode = cst_pkg::M_IDLE;
                    end
                    else
                    begin
                        d.adv = 2'd1;
                    end
                end
                default:
                begin
                    d.mode = cst_pkg::M_IDLE;
                end
            endcase
            if (d.emit)
            begin
                d.mode = cst_pkg::M_IDLE;
            end
        end
    end

    // datapath
    always_comb
    begin
        mode_next     = mode_reg;
        win_next      = win_reg;
        cnt_next      = cnt_reg;
        off_next      = off_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        acr_next      = acr_reg;
        ts_off_next   = ts_off_reg;
        ts_line_next  = ts_line_reg;
        ts_col_next   = ts_col_reg;
        sfp_next      = sfp_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        push          = 1'b0;
        push_data     = pend_reg;
        deq           = 1'b0;
        take          = d.skip_lf ? 2'd1 : d.adv;

        case (d.adv)
            2'd1:    off_a = sat1(off_reg);
            2'd2:    off_a = sat2(off_reg);
            default: off_a = off_reg;
        endcase
        st_off  = d.mark ? off_reg : ts_off_reg;
        st_line = d.mark ? line_reg : ts_line_reg;
        st_col  = d.mark ? col_reg : ts_col_reg;

        if (en)
        begin
            case (d.st)
                cst_pkg::ST_NEED:
                begin
                    // the byte's run is over: release the held token as its last
                    if (pend_vld_reg)
                    begin
                        push           = 1'b1;
                        push_data.last = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                    if (cnt_reg != 2'd0)
                    begin
                        acr_next = 1'b0;
                    end
                    if (q_valid && cnt_reg != 2'd3)
                    begin
                        deq = 1'b1;
                        case (cnt_reg)
                            2'd0:    win_next[0] = q_data;
                            2'd1:    win_next[1] = q_data;
                            default: win_next[2] = q_data;
                        endcase
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                cst_pkg::ST_GO:
                begin
                    acr_next = 1'b0;
                    if (d.skip_lf)
                    begin
                        off_next = sat1(off_reg);
                    end
                    else
                    begin
                        off_next  = off_a;
                        mode_next = d.mode;
                        if (d.adv == 2'd1)
                        begin
                            if (c0.ch == cst_pkg::CH_LF || c0.ch == cst_pkg::CH_CR)
                            begin
                                line_next = sat1(line_reg);
                                col_next  = ONE;
                                acr_next  = (c0.ch == cst_pkg::CH_CR);
                            end
                            else
                            begin
                                col_next = sat1(col_reg);
                            end
                        end
                        else if (d.adv == 2'd2)
                        begin
                            col_next = sat2(col_reg);
                        end
                        if (d.mark)
                        begin
                            ts_off_next  = off_reg;
                            ts_line_next = line_reg;
                            ts_col_next  = col_reg;
                        end
                        if (d.sfp_set)
                        begin
                            sfp_next = 1'b1;
                        end
                        if (d.emit)
                        begin
                            sfp_next = 1'b0;
                            if (pend_vld_reg)
                            begin
                                push           = 1'b1;
                                push_data.last = 1'b0;
                            end
                            pend_next.cls  = d.cls;
                            pend_next.off  = cst_pkg::OUT_W'(st_off);
                            pend_next.len  = cst_pkg::OUT_W'(off_a - st_off);
                            pend_next.line = cst_pkg::OUT_W'(st_line);
                            pend_next.col  = cst_pkg::OUT_W'(st_col);
                            pend_next.last = 1'b0;
                            pend_vld_next  = 1'b1;
                        end
                    end
                    case (take)
                        2'd1:
                        begin
                            win_next[0] = win_reg[1];
                            win_next[1] = win_reg[2];
                        end
                        2'd2:
                        begin
                            win_next[0] = win_reg[2];
                        end
                        default:
                        begin
                            win_next[0] = win_reg[0];
                        end
                    endcase
                    cnt_next = cnt_reg - take;
                end
                cst_pkg::ST_END:
                begin
                    if (pend_vld_reg)
                    begin
                        push           = 1'b1;
                        push_data.last = 1'b0;
                    end
                    pend_next.cls  = cst_pkg::CL_END;
                    pend_next.off  = cst_pkg::OUT_W'(off_reg);
                    pend_next.len  = '0;
                    pend_next.line = cst_pkg::OUT_W'(line_reg);
                    pend_next.col  = cst_pkg::OUT_W'(col_reg);
                    pend_next.last = 1'b0;
                    pend_vld_next  = 1'b1;
                    mode_next      = cst_pkg::M_IDLE;
                    cnt_next       = 2'd0;
                    off_next       = '0;
                    line_next      = ONE;
                    col_next       = ONE;
                    acr_next       = 1'b0;
                    ts_off_next    = '0;
                    ts_line_next   = ONE;
                    ts_col_next    = ONE;
                    sfp_next       = 1'b0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg   <= win_next;
        pend_reg  <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= cst_pkg::M_IDLE;
            cnt_reg      <= '0;
            off_reg      <= '0;
            line_reg     <= ONE;
            col_reg      <= ONE;
            acr_reg      <= 1'b0;
            ts_off_reg   <= '0;
            ts_line_reg  <= ONE;
            ts_col_reg   <= ONE;
            sfp_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            cnt_reg      <= cnt_next;
            off_reg      <= off_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            acr_reg      <= acr_next;
            ts_off_reg   <= ts_off_next;
            ts_line_reg  <= ts_line_next;
            ts_col_reg   <= ts_col_next;
            sfp_reg      <= sfp_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

endmodule

FILE: rtl/core/c_style_source_tokenizer_top.sv
// ----------------------------------------------------------------
// c_style_source_tokenizer_top
// Flow: a byte costs a fetch step plus the scan steps that consume it (state changes
//   that consume nothing cost a step); scanning halts while the token queue is full.
// Path: byte to token through the input queue, a scan step, the token hold and the
//   output queue; a token that waits on lookahead leaves once the next byte is scanned.
// Reset: rst_n clears queues and scanner state; position starts at offset 0, line 1, col 1.
// ----------------------------------------------------------------
module c_style_source_tokenizer_top #(
    parameter int POSITION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_class,
    output logic [23:0] start_offset,
    output logic [23:0] token_length,
    output logic [23:0] start_line,
    output logic [23:0] start_column,
    output logic        last_of_run
);

    logic            q_valid;
    cst_pkg::qent_t  q_data;
    logic            deq;
    logic            oq_full;
    logic            push;
    cst_pkg::token_t push_data;
    cst_pkg::token_t head;

    cst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .deq       (deq),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    cst_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .deq       (deq),
        .oq_full   (oq_full),
        .push      (push),
        .push_data (push_data)
    );

    cst_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (oq_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign token_class  = head.cls;
    assign start_offset = head.off;
    assign token_length = head.len;
    assign start_line   = head.line;
    assign start_column = head.col;
    assign last_of_run  = head.last;

endmodule
